[rtl/core/mlfq_pkg.sv]
// Shared types, codes and constants of the multilevel feedback queue scheduler.
package mlfq_pkg;

	localparam int LEVELS_DEF      = 3;
	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int LVL_W    = 2;
	localparam int PID_W    = 8;
	localparam int SIZE_W   = 16;
	localparam int SLICE_W  = 16;
	localparam int AFTER_W  = 17;
	localparam int ENTRY_W  = PID_W + SIZE_W;

	localparam int NUM_SLICES = 3;
	localparam int CFG_IDX_W  = 2;

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 64;

	typedef logic [SLICE_W-1:0] slice_t;

	localparam slice_t SLICE_RESET [NUM_SLICES] = '{16'd10, 16'd20, 16'd40};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLICE0 = 2'd0,
		REG_SLICE1 = 2'd1,
		REG_SLICE2 = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_BAD,
		OP_DISPATCH
	} op_t;

	typedef enum logic [2:0] {
		ST_ADDED    = 3'd0,
		ST_BAD      = 3'd1,
		ST_FULL     = 3'd2,
		ST_DEMOTED  = 3'd3,
		ST_FINISHED = 3'd4,
		ST_IDLE     = 3'd5,
		ST_DROPPED  = 3'd6
	} status_t;

	typedef enum logic {
		B_IDLE,
		B_READ
	} back_state_t;

	typedef struct packed {
		op_t               op;
		logic [LVL_W-1:0]  level;
		logic [SIZE_W-1:0] size;
		logic [PID_W-1:0]  pid;
	} cmd_t;

	typedef struct packed {
		status_t                    status;
		logic [PID_W-1:0]           pid;
		logic [LVL_W-1:0]           run_level;
		logic [LVL_W-1:0]           next_level;
		logic [SLICE_W-1:0]         slice_used;
		logic [SIZE_W-1:0]          size_before;
		logic signed [AFTER_W-1:0]  size_after;
	} result_t;

endpackage

[rtl/core/mlfq_front.sv]
// Front end: accepts items, stamps add items with a process id and classifies them.
module mlfq_front import mlfq_pkg::*; #(
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tuser,
	input  logic                 cmd_full,
	output logic                 cmd_push,
	output cmd_t                 cmd
);

	logic [PID_W-1:0]  next_pid_q;
	logic [PID_W-1:0]  pid_new;
	logic [LVL_W-1:0]  prio;
	logic [SIZE_W-1:0] psize;

	assign prio     = s_tdata[LVL_W-1:0];
	assign psize    = s_tdata[LVL_W+SIZE_W-1:LVL_W];
	assign pid_new  = next_pid_q + PID_W'(1);
	assign s_tready = !cmd_full;
	assign cmd_push = s_tvalid && s_tready;

	always_comb begin
		cmd.level = prio;
		cmd.size  = psize;
		cmd.pid   = pid_new;
		if (s_tuser) begin
			cmd.op = OP_DISPATCH;
		end else if (32'(prio) >= LEVELS) begin
			cmd.op = OP_BAD;
		end else begin
			cmd.op = OP_ADD;
		end
	end

	// Every add item consumes an id, rejected ones included.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_pid_q <= '0;
		end else if (cmd_push && !s_tuser) begin
			next_pid_q <= pid_new;
		end
	end

endmodule

[rtl/core/mlfq_cmdq.sv]
// Short command queue between the front end and the scheduling back end.
module mlfq_cmdq import mlfq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t head_cmd
);

	cmd_t               entry_q [CMDQ_DEPTH];
	logic [CMDQ_PW-1:0] wr_ptr_q;
	logic [CMDQ_PW-1:0] rd_ptr_q;
	logic [CMDQ_CW-1:0] cnt_q;

	assign full     = cnt_q == CMDQ_CW'(CMDQ_DEPTH);
	assign valid    = cnt_q != '0;
	assign head_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + CMDQ_PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + CMDQ_PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CMDQ_CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CMDQ_CW'(1);
			end
		end
	end

endmodule

[rtl/core/mlfq_back.sv]
// Back end: per-level FIFOs in one memory, enqueue, dispatch and demotion.
module mlfq_back import mlfq_pkg::*; #(
	parameter int LEVELS      = LEVELS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  slice_t [NUM_SLICES-1:0]      slices,
	input  logic                         cmd_valid,
	input  cmd_t                         cmd,
	output logic                         cmd_pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output result_t                      result
);

	localparam int TOTAL = LEVELS * QUEUE_DEPTH;
	localparam int AW    = $clog2(TOTAL);
	localparam int PW    = $clog2(QUEUE_DEPTH);
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	logic [ENTRY_W-1:0] mem [TOTAL];
	logic [ENTRY_W-1:0] rd_data_q;

	back_state_t       state_q, state_d;
	logic [CW-1:0]     cnt_q  [LEVELS];
	logic [PW-1:0]     head_q [LEVELS];
	logic [PW-1:0]     tail_q [LEVELS];
	logic [LVL_W-1:0]  rd_lvl_q;
	logic              out_valid_q;
	result_t           result_q;

	logic              out_free;
	logic              any_ready;
	logic [LVL_W-1:0]  sel_lvl;
	logic              push_en, pop_en, rd_en, load_out;
	logic [LVL_W-1:0]  push_lvl;
	logic [ENTRY_W-1:0] push_data;
	logic [AW-1:0]     wr_addr, rd_addr;
	result_t           result_d;

	logic [PID_W-1:0]           rd_pid;
	logic [SIZE_W-1:0]          rd_before;
	slice_t                     rd_slice;
	logic signed [AFTER_W-1:0]  rd_after;
	logic [LVL_W-1:0]           demote_lvl;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign result    = result_q;

	assign rd_pid     = rd_data_q[ENTRY_W-1:SIZE_W];
	assign rd_before  = rd_data_q[SIZE_W-1:0];
	assign rd_slice   = slices[rd_lvl_q];
	assign rd_after   = $signed({1'b0, rd_before}) - $signed({1'b0, rd_slice});
	assign demote_lvl = (32'(rd_lvl_q) + 1 < LEVELS) ? rd_lvl_q + LVL_W'(1) : rd_lvl_q;

	// Highest-priority level with a waiting process.
	always_comb begin
		sel_lvl   = '0;
		any_ready = 1'b0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (cnt_q[i] != '0) begin
				sel_lvl   = LVL_W'(i);
				any_ready = 1'b1;
			end
		end
	end

	assign wr_addr = AW'(push_lvl) * AW'(QUEUE_DEPTH) + AW'(tail_q[push_lvl[LW-1:0]]);
	assign rd_addr = AW'(sel_lvl) * AW'(QUEUE_DEPTH) + AW'(head_q[sel_lvl[LW-1:0]]);

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		push_en   = 1'b0;
		push_lvl  = '0;
		push_data = '0;
		pop_en    = 1'b0;
		rd_en     = 1'b0;
		load_out  = 1'b0;
		result_d  = '0;
		unique case (state_q)
			B_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_pop         = 1'b1;
					result_d.pid    = cmd.pid;
					unique case (cmd.op)
						OP_BAD: begin
							load_out        = 1'b1;
							result_d.status = ST_BAD;
						end
						OP_ADD: begin
							load_out             = 1'b1;
							result_d.run_level   = cmd.level;
							result_d.size_before = cmd.size;
							push_lvl             = cmd.level;
							push_data            = {cmd.pid, cmd.size};
							if (cnt_q[cmd.level[LW-1:0]] == CW'(QUEUE_DEPTH)) begin
								result_d.status = ST_FULL;
							end else begin
								result_d.status = ST_ADDED;
								push_en         = 1'b1;
							end
						end
						OP_DISPATCH: begin
							if (any_ready) begin
								rd_en   = 1'b1;
								pop_en  = 1'b1;
								state_d = B_READ;
							end else begin
								load_out        = 1'b1;
								result_d        = '0;
								result_d.status = ST_IDLE;
							end
						end
						default: begin
							load_out        = 1'b1;
							result_d.status = ST_BAD;
						end
					endcase
				end
			end
			B_READ: begin
				load_out             = 1'b1;
				state_d              = B_IDLE;
				result_d.pid         = rd_pid;
				result_d.run_level   = rd_lvl_q;
				result_d.slice_used  = rd_slice;
				result_d.size_before = rd_before;
				result_d.size_after  = rd_after;
				if (rd_before > rd_slice) begin
					result_d.next_level = demote_lvl;
					push_lvl            = demote_lvl;
					push_data           = {rd_pid, rd_after[SIZE_W-1:0]};
					if (cnt_q[demote_lvl[LW-1:0]] == CW'(QUEUE_DEPTH)) begin
						result_d.status = ST_DROPPED;
					end else begin
						result_d.status = ST_DEMOTED;
						push_en         = 1'b1;
					end
				end else begin
					result_d.status = ST_FINISHED;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			mem[wr_addr] <= push_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (rd_en) begin
			rd_lvl_q <= sel_lvl;
		end
		if (load_out) begin
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Pointer wrap is by compare, so any depth in range works.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				cnt_q[i]  <= '0;
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < LEVELS; i++) begin
				if (push_en && push_lvl == LVL_W'(i)) begin
					cnt_q[i]  <= cnt_q[i] + CW'(1);
					tail_q[i] <= (tail_q[i] == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_q[i] + PW'(1);
				end
				if (pop_en && sel_lvl == LVL_W'(i)) begin
					cnt_q[i]  <= cnt_q[i] - CW'(1);
					head_q[i] <= (head_q[i] == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q[i] + PW'(1);
				end
			end
		end
	end

	for (genvar g = 0; g < LEVELS; g++) begin : g_cnt_chk
		a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
			cnt_q[g] <= CW'(QUEUE_DEPTH))
			else $error("level fill count beyond queue depth");
	end

	a_push_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(push_en && pop_en))
		else $error("push and pop in the same cycle");

	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_READ |-> !out_valid_q)
		else $error("dispatch read while a result is still held");

	a_read_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_READ |=> state_q == B_IDLE)
		else $error("dispatch read state held longer than one cycle");

endmodule

[rtl/core/mlfq_scheduler.sv]
// Top level of the multilevel feedback queue scheduler: config registers and wiring.
//
// Channel   Direction  Handshake           Payload
// s_*       in         s_tvalid/s_tready   tuser kind, tdata priority_req, process_size
// m_*       out        m_tvalid/m_tready   tuser status, tdata result fields
// cfg_*     in         cfg_we              slice_level0..2 by cfg_index
//
// An item is registered in the command queue before the back end takes it. In the back
// end an add or an idle dispatch is answered from the idle state, while a dispatch of a
// waiting process also passes the read state, for the registered read of the level memory.
// Reset clears all levels, the id counter and the queue; the memory holds no reset.
// A stalled output holds the back end, and the command queue then fills and drops
// s_tready.
module mlfq_scheduler import mlfq_pkg::*; #(
	parameter int LEVELS      = LEVELS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [1:0] priority_req, [17:2] process_size, rest zero
	input  logic [S_TDATA_W-1:0] s_tdata,
	// [0] kind
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [7:0] process_id, [9:8] run_level, [11:10] next_level, [27:12] slice_used,
	// [43:28] size_before, [60:44] size_after, rest zero
	output logic [M_TDATA_W-1:0] m_tdata,
	// [2:0] status
	output logic [2:0]           m_tuser,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SLICE_W-1:0]   cfg_wdata
);

	slice_t [NUM_SLICES-1:0] slice_q;
	logic                    cmd_full, cmd_push, cmd_valid, cmd_pop;
	cmd_t                    front_cmd, head_cmd;
	result_t                 result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLICES; i++) begin
				slice_q[i] <= SLICE_RESET[i];
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SLICE0: slice_q[0] <= cfg_wdata;
				REG_SLICE1: slice_q[1] <= cfg_wdata;
				REG_SLICE2: slice_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	mlfq_front #(
		.LEVELS(LEVELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd      (front_cmd)
	);

	mlfq_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (front_cmd),
		.full     (cmd_full),
		.pop      (cmd_pop),
		.valid    (cmd_valid),
		.head_cmd (head_cmd)
	);

	mlfq_back #(
		.LEVELS      (LEVELS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.slices    (slice_q),
		.cmd_valid (cmd_valid),
		.cmd       (head_cmd),
		.cmd_pop   (cmd_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.result    (result)
	);

	assign m_tuser = result.status;
	assign m_tdata = {3'b000, result.size_after, result.size_before, result.slice_used,
		result.next_level, result.run_level, result.pid};

endmodule

[dv/tb_top.sv]
// Self-checking testbench of the multilevel feedback queue scheduler with an in-bench predictor.
module tb_top import mlfq_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic KIND_ADD      = 1'b0;
	localparam logic KIND_DISPATCH = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam logic [LVL_W-1:0] PRIO_BAD = 2'd3;

	localparam int SETTLE_CYCLES = 8;
	localparam int PHASES        = 14;
	localparam int PHASE_ITEMS   = 125;

	typedef enum logic [1:0] {
		PEND_ITEM,
		PEND_CFG,
		PEND_PAUSE
	} pend_act_t;

	typedef struct packed {
		pend_act_t              act;
		logic                   kind;
		logic [LVL_W-1:0]       prio;
		logic [SIZE_W-1:0]      size;
		logic [CFG_IDX_W-1:0]   idx;
		logic [SLICE_W-1:0]     val;
		logic [3:0]             gap;
	} pend_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic                 s_tuser   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [2:0]           m_tuser;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SLICE_W-1:0]   cfg_wdata = '0;

	mlfq_scheduler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	// Predicted scheduler state.
	logic [ENTRY_W-1:0] lvl_mem [LEVELS_DEF][QUEUE_DEPTH_DEF];
	int                 lvl_head [LEVELS_DEF] = '{default: 0};
	int                 lvl_tail [LEVELS_DEF] = '{default: 0};
	int                 lvl_cnt  [LEVELS_DEF] = '{default: 0};
	logic [PID_W-1:0]   pid_ctr = '0;
	slice_t             slice_cfg [NUM_SLICES] = SLICE_RESET;

	pend_t   sched_feed [$];
	result_t results_due [$];

	bit      failed    = 1'b0;
	bit      feed_done = 1'b0;
	bit      idle_on   = 1'b1;
	bit      stall_on  = 1'b1;
	int      gap_left   = 0;
	int      settle_cnt = 0;
	int      stall_left = 0;
	pend_t   cur;
	logic    drv_valid;
	logic    drv_we;
	logic    mon_ready;
	result_t want;
	result_t got;

	function automatic bit lvl_push(int lvl, logic [ENTRY_W-1:0] entry);
		if (lvl_cnt[lvl] >= QUEUE_DEPTH_DEF)
			return 1'b0;
		lvl_mem[lvl][lvl_tail[lvl]] = entry;
		lvl_tail[lvl] = (lvl_tail[lvl] + 1) % QUEUE_DEPTH_DEF;
		lvl_cnt[lvl]++;
		return 1'b1;
	endfunction

	function automatic result_t sched_predict(logic kind, logic [LVL_W-1:0] prio,
			logic [SIZE_W-1:0] size);
		result_t            res;
		int                 lvl;
		int                 nl;
		logic [ENTRY_W-1:0] entry;
		slice_t             slice;
		res = '0;
		lvl = LEVELS_DEF;
		if (kind == KIND_ADD) begin
			// The id is used up even when the add is rejected.
			pid_ctr = pid_ctr + 8'd1;
			res.pid = pid_ctr;
			if (prio >= LEVELS_DEF) begin
				res.status = ST_BAD;
			end else begin
				res.run_level   = prio;
				res.size_before = size;
				res.status      = lvl_push(int'(prio), {pid_ctr, size}) ? ST_ADDED : ST_FULL;
			end
		end else begin
			for (int i = LEVELS_DEF - 1; i >= 0; i--)
				if (lvl_cnt[i] != 0)
					lvl = i;
			if (lvl == LEVELS_DEF) begin
				res.status = ST_IDLE;
			end else begin
				entry = lvl_mem[lvl][lvl_head[lvl]];
				lvl_head[lvl] = (lvl_head[lvl] + 1) % QUEUE_DEPTH_DEF;
				lvl_cnt[lvl]--;
				slice = slice_cfg[lvl];
				res.pid         = entry[ENTRY_W-1:SIZE_W];
				res.run_level   = lvl[LVL_W-1:0];
				res.slice_used  = slice;
				res.size_before = entry[SIZE_W-1:0];
				res.size_after  = {1'b0, entry[SIZE_W-1:0]} - {1'b0, slice};
				if (entry[SIZE_W-1:0] > slice) begin
					nl = (lvl + 1 < LEVELS_DEF) ? lvl + 1 : lvl;
					res.next_level = nl[LVL_W-1:0];
					res.status = lvl_push(nl, {entry[ENTRY_W-1:SIZE_W],
						res.size_after[SIZE_W-1:0]}) ? ST_DEMOTED : ST_DROPPED;
				end else begin
					res.status = ST_FINISHED;
				end
			end
		end
		return res;
	endfunction

	function automatic void feed_item(logic kind, logic [LVL_W-1:0] prio,
			logic [SIZE_W-1:0] size);
		pend_t p;
		p      = '0;
		p.act  = PEND_ITEM;
		p.kind = kind;
		p.prio = prio;
		p.size = size;
		p.gap  = idle_on ? 4'($urandom_range(0, 12)) : 4'd0;
		sched_feed.push_back(p);
	endfunction

	function automatic void feed_cfg(logic [CFG_IDX_W-1:0] idx, logic [SLICE_W-1:0] val);
		pend_t p;
		p     = '0;
		p.act = PEND_CFG;
		p.idx = idx;
		p.val = val;
		sched_feed.push_back(p);
	endfunction

	function automatic void feed_slices(slice_t s0, slice_t s1, slice_t s2);
		feed_cfg(REG_SLICE0, s0);
		feed_cfg(REG_SLICE1, s1);
		feed_cfg(REG_SLICE2, s2);
	endfunction

	function automatic void feed_pause();
		pend_t p;
		p     = '0;
		p.act = PEND_PAUSE;
		sched_feed.push_back(p);
	endfunction

	function automatic void check_field(string what, longint exp_val, longint act_val);
		if (exp_val != act_val) begin
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, what, exp_val,
				act_val);
			failed = 1'b1;
		end
	endfunction

	// Driver: the prediction is made at the edge where the item is accepted. Configuration
	// writes and pauses wait until every result has come and the block has settled.
	always @(posedge clk) begin
		if (arst_n) begin
			drv_valid = s_tvalid;
			drv_we    = 1'b0;
			if (s_tvalid && s_tready) begin
				results_due.push_back(sched_predict(s_tuser, s_tdata[1:0], s_tdata[17:2]));
				drv_valid = 1'b0;
			end
			if (!drv_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (sched_feed.size() != 0) begin
					if (sched_feed[0].act == PEND_ITEM) begin
						cur = sched_feed.pop_front();
						s_tdata   <= {6'd0, cur.size, cur.prio};
						s_tuser   <= cur.kind;
						gap_left  = int'(cur.gap);
						drv_valid = 1'b1;
					end else if (results_due.size() != 0) begin
						settle_cnt = 0;
					end else if (settle_cnt < SETTLE_CYCLES) begin
						settle_cnt++;
					end else begin
						cur = sched_feed.pop_front();
						settle_cnt = 0;
						if (cur.act == PEND_CFG) begin
							drv_we = 1'b1;
							cfg_index <= cur.idx;
							cfg_wdata <= cur.val;
							if (cur.idx < NUM_SLICES)
								slice_cfg[cur.idx] = cur.val;
						end
					end
				end else begin
					feed_done = 1'b1;
				end
			end
			s_tvalid <= drv_valid;
			cfg_we   <= drv_we;
		end
	end

	// Monitor: compares each result with the oldest prediction and draws its own stalls.
	always @(posedge clk) begin
		if (arst_n) begin
			mon_ready = m_tready;
			if (m_tvalid && m_tready) begin
				got.status      = status_t'(m_tuser);
				got.pid         = m_tdata[7:0];
				got.run_level   = m_tdata[9:8];
				got.next_level  = m_tdata[11:10];
				got.slice_used  = m_tdata[27:12];
				got.size_before = m_tdata[43:28];
				got.size_after  = m_tdata[60:44];
				if (results_due.size() == 0) begin
					$display("%0t unexpected result: expected none, actual status %0d tdata %h",
						$time, m_tuser, m_tdata);
					failed = 1'b1;
				end else begin
					want = results_due.pop_front();
					check_field("status", longint'(want.status), longint'(got.status));
					check_field("process_id", longint'(want.pid), longint'(got.pid));
					check_field("run_level", longint'(want.run_level),
						longint'(got.run_level));
					check_field("next_level", longint'(want.next_level),
						longint'(got.next_level));
					check_field("slice_used", longint'(want.slice_used),
						longint'(got.slice_used));
					check_field("size_before", longint'(want.size_before),
						longint'(got.size_before));
					check_field("size_after", longint'(want.size_after),
						longint'(got.size_after));
				end
				stall_left = stall_on ? int'($urandom_range(0, 12)) : 0;
				if ($urandom_range(0, 99) == 0)
					stall_on = !stall_on;
				mon_ready = (stall_left == 0);
			end else if (!m_tready) begin
				if (stall_left > 0)
					stall_left--;
				mon_ready = (stall_left == 0);
			end
			m_tready <= mon_ready;
		end
	end

	initial begin
		logic              kind;
		logic [LVL_W-1:0]  prio;
		logic [SIZE_W-1:0] size;
		int                add_pct;
		int                pick;

		// Directed part under the reset slices.
		feed_item(KIND_DISPATCH, 2'd0, 16'd0);
		feed_item(KIND_ADD, PRIO_BAD, 16'hFFFF);
		feed_item(KIND_ADD, 2'd0, 16'd0);
		feed_item(KIND_ADD, 2'd0, 16'hFFFF);
		feed_item(KIND_ADD, 2'd1, 16'd1);
		feed_item(KIND_ADD, 2'd2, 16'd40);
		feed_item(KIND_ADD, 2'd2, 16'd41);
		feed_item(KIND_ADD, 2'd1, 16'd20);
		for (int i = 0; i < 9; i++)
			feed_item(KIND_DISPATCH, PRIO_BAD, 16'hFFFF);
		feed_item(KIND_DISPATCH, 2'd0, 16'd0);
		// A zero slice leaves the work as it is.
		feed_slices(16'd0, 16'd0, 16'd0);
		feed_item(KIND_ADD, 2'd0, 16'd0);
		feed_item(KIND_ADD, 2'd2, 16'd5);
		feed_item(KIND_DISPATCH, 2'd0, 16'd0);
		feed_item(KIND_DISPATCH, 2'd0, 16'd0);
		feed_item(KIND_DISPATCH, 2'd0, 16'd0);
		feed_cfg(REG_UNUSED, 16'h1234);
		feed_pause();

		// Random phases, each with its own slices, add ratio and idling.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 7)
				0: feed_slices(SLICE_RESET[0], SLICE_RESET[1], SLICE_RESET[2]);
				1: feed_slices(16'd1, 16'd1, 16'd1);
				2: feed_slices(16'hFFFF, 16'hFFFF, 16'hFFFF);
				3: feed_slices(16'd0, 16'd0, 16'd0);
				4: feed_slices(SLICE_W'($urandom_range(1, 64)),
					SLICE_W'($urandom_range(1, 64)), SLICE_W'($urandom_range(1, 64)));
				5: begin
					feed_slices(SLICE_W'($urandom), SLICE_W'($urandom), SLICE_W'($urandom));
					feed_cfg(REG_UNUSED, SLICE_W'($urandom));
				end
				default: feed_slices(16'd0, 16'hFFFF, 16'd1);
			endcase
			idle_on = (ph % 3 != 1);
			add_pct = 25 * int'($urandom_range(1, 3));
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 149) == 0)
					feed_pause();
				kind = ($urandom_range(0, 99) < add_pct) ? KIND_ADD : KIND_DISPATCH;
				prio = ($urandom_range(0, 15) == 0) ? PRIO_BAD : LVL_W'($urandom_range(0, 2));
				pick = int'($urandom_range(0, 9));
				if (pick == 0)
					size = 16'd0;
				else if (pick == 1)
					size = 16'hFFFF;
				else if (pick < 6)
					size = SIZE_W'($urandom_range(0, 100));
				else if (pick < 8)
					size = SIZE_W'($urandom_range(0, 1000));
				else
					size = SIZE_W'($urandom);
				feed_item(kind, prio, size);
			end
			feed_pause();
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (!(feed_done && results_due.size() == 0))
			@(posedge clk);
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		if (!failed)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
